@@ design/b32dec_pkg.sv @@
`default_nettype none
package b32dec_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_SYMBOL  = 2'd1;
  localparam status_t ST_PADDING = 2'd2;
  localparam status_t ST_LENGTH  = 2'd3;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [3:0] PAD_LIMIT   = 4'd8;
  localparam logic [2:0] GROUP_LAST  = 3'd7;
  localparam logic [2:0] GROUP_BYTES = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [4:0] value;
  } sym_t;

  function automatic sym_t sym_value(input logic [7:0] ch);
    sym_t s;
    s.valid = 1'b1;
    s.value = 5'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = 5'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = 5'(ch - 8'h61);
    end else if (ch >= 8'h32 && ch <= 8'h37) begin
      s.value = 5'(ch - 8'h32 + 8'd26);
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [2:0] tail_bytes(input logic [3:0] pads);
    logic [2:0] n;
    case (pads)
      4'd0:    n = 3'd5;
      4'd1:    n = 3'd4;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd6:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] tail_offset(input logic [3:0] pads);
    logic [2:0] n;
    case (pads)
      4'd1:    n = 3'd3;
      4'd3:    n = 3'd1;
      4'd4:    n = 3'd4;
      4'd6:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ design/base32_strict_decoder_top.sv @@
`default_nettype none
// Strict base32 decoder. At most one character is taken per cycle on the slave
// side (s_tlast on the final character of a text). Each closed group of eight
// characters is decoded in the accepting cycle into a holding register. The
// holding register passes the group to a five-byte output register when that
// register is empty or is sending its last byte. The output register sends one
// byte per cycle while m_tready is high, most significant first. A group's
// bytes are registered in the holding register, then in the output register.
// A character is taken whenever the holding register is empty or is being
// emptied. So with no stall on the master side one character enters every
// cycle, except while the holding register is full and not being emptied,
// for example after an error right after a full group.
// An error gives one result with data 0 and a nonzero status in m_tuser, and
// later characters up to the end of the text are dropped without result.
module base32_strict_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] symbol_char
  input  wire logic       s_tlast,   // text_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] data_byte
  output logic [2:0]      m_tuser,   // [0] run_end, [2:1] status
  output logic            m_tlast    // text_done
);

  logic [39:0] group_bits, group_bits_next;
  logic [2:0]  symbol_count, symbol_count_next;
  logic [3:0]  pad_count, pad_count_next;
  logic        drain_after_error, drain_after_error_next;

  logic [39:0] pend_bits, pend_bits_next;
  logic [2:0]  pend_count, pend_count_next;
  logic        pend_last, pend_last_next;
  b32dec_pkg::status_t pend_status, pend_status_next;

  logic [39:0] out_bits, out_bits_next;
  logic [2:0]  out_count, out_count_next;
  logic        out_last, out_last_next;
  b32dec_pkg::status_t out_status, out_status_next;

  logic       accept, take, is_pad, out_load;
  b32dec_pkg::sym_t sym;
  b32dec_pkg::status_t char_status;
  logic [3:0] pads_new, pads_cap;
  logic [39:0] bits_new;
  logic [2:0] nbytes, offset, unused_bytes;
  logic [39:0] shifted;

  assign take     = m_tvalid && m_tready;
  assign out_load = (pend_count != 3'd0) &&
                    ((out_count == 3'd0) || ((out_count == 3'd1) && m_tready));
  assign s_tready = (pend_count == 3'd0) || out_load;
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid = out_count != 3'd0;
  assign m_tdata  = out_bits[39:32];
  assign m_tuser  = {out_status, out_count == 3'd1};
  assign m_tlast  = (out_count == 3'd1) && out_last;

  assign is_pad       = s_tdata == b32dec_pkg::PAD_CHAR;
  assign sym          = b32dec_pkg::sym_value(s_tdata);
  assign pads_new     = is_pad ? pad_count + 4'd1 : pad_count;
  assign pads_cap     = (pads_new > b32dec_pkg::PAD_LIMIT) ? b32dec_pkg::PAD_LIMIT : pads_new;
  assign bits_new     = is_pad ? group_bits : {group_bits[34:0], sym.value};
  assign nbytes       = b32dec_pkg::tail_bytes(pads_cap);
  assign offset       = b32dec_pkg::tail_offset(pads_cap);
  assign unused_bytes = b32dec_pkg::GROUP_BYTES - nbytes;
  assign shifted      = (bits_new >> offset) << {unused_bytes, 3'b000};

  always_comb begin
    group_bits_next        = group_bits;
    symbol_count_next      = symbol_count;
    pad_count_next         = pad_count;
    drain_after_error_next = drain_after_error;
    pend_bits_next         = pend_bits;
    pend_count_next        = pend_count;
    pend_last_next         = pend_last;
    pend_status_next       = pend_status;
    out_bits_next          = out_bits;
    out_count_next         = out_count;
    out_last_next          = out_last;
    out_status_next        = out_status;
    char_status            = b32dec_pkg::ST_OK;

    if (take) begin
      out_bits_next  = {out_bits[31:0], 8'h00};
      out_count_next = out_count - 3'd1;
    end

    if (out_load) begin
      out_bits_next   = pend_bits;
      out_count_next  = pend_count;
      out_last_next   = pend_last;
      out_status_next = pend_status;
      pend_count_next = 3'd0;
    end

    if (accept) begin
      if (drain_after_error) begin
        if (s_tlast) begin
          drain_after_error_next = 1'b0;
        end
      end else begin
        if (!is_pad && pad_count != 4'd0) begin
          char_status = b32dec_pkg::ST_PADDING;
        end else if (!is_pad && !sym.valid) begin
          char_status = b32dec_pkg::ST_SYMBOL;
        end else if (symbol_count == b32dec_pkg::GROUP_LAST) begin
          if (nbytes == 3'd0 || (pads_cap != 4'd0 && !s_tlast)) begin
            char_status = b32dec_pkg::ST_PADDING;
          end
        end else if (s_tlast) begin
          char_status = b32dec_pkg::ST_LENGTH;
        end

        if (char_status != b32dec_pkg::ST_OK) begin
          // report once, then drop to end of text
          pend_bits_next         = '0;
          pend_count_next        = 3'd1;
          pend_last_next         = 1'b1;
          pend_status_next       = char_status;
          group_bits_next        = '0;
          symbol_count_next      = 3'd0;
          pad_count_next         = 4'd0;
          drain_after_error_next = !s_tlast;
        end else if (symbol_count == b32dec_pkg::GROUP_LAST) begin
          pend_bits_next    = shifted;
          pend_count_next   = nbytes;
          pend_last_next    = s_tlast;
          pend_status_next  = b32dec_pkg::ST_OK;
          group_bits_next   = '0;
          symbol_count_next = 3'd0;
          pad_count_next    = 4'd0;
        end else begin
          group_bits_next   = bits_new;
          pad_count_next    = pads_new;
          symbol_count_next = symbol_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits        <= '0;
      symbol_count      <= '0;
      pad_count         <= '0;
      drain_after_error <= 1'b0;
      pend_count        <= '0;
      out_count         <= '0;
    end else begin
      group_bits        <= group_bits_next;
      symbol_count      <= symbol_count_next;
      pad_count         <= pad_count_next;
      drain_after_error <= drain_after_error_next;
      pend_count        <= pend_count_next;
      out_count         <= out_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_bits   <= pend_bits_next;
    pend_last   <= pend_last_next;
    pend_status <= pend_status_next;
    out_bits    <= out_bits_next;
    out_last    <= out_last_next;
    out_status  <= out_status_next;
  end

endmodule
`default_nettype wire

@@ bench/b32_stream_checker.sv @@
`default_nettype none
module b32_stream_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] symbol_char
  input  wire logic       s_tlast,   // text_end
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,   // [7:0] data_byte
  input  wire logic [2:0] m_tuser,   // [0] run_end, [2:1] status
  input  wire logic       m_tlast,   // text_done
  output int              results_owed,
  output int              mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       text_done;
    b32dec_pkg::status_t status;
  } b32_result_t;

  b32_result_t owed_q[$];
  b32_result_t want;

  logic [39:0] grp_bits;
  logic [2:0]  sym_cnt;
  logic [3:0]  pad_cnt;
  logic        draining;

  task automatic report(input string what);
    if (mismatches < 40) $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_group();
    grp_bits = '0;
    sym_cnt  = '0;
    pad_cnt  = '0;
    draining = 1'b0;
  endfunction

  function automatic void flag_error(input b32dec_pkg::status_t code, input logic lst);
    owed_q.push_back('{8'h00, 1'b1, 1'b1, code});
    clear_group();
    draining = !lst;
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic lst);
    logic [4:0]  val;
    logic        known;
    int          nbytes;
    int          shift;
    logic [39:0] aligned;
    if (draining) begin
      if (lst) clear_group();
      return;
    end
    if (ch == b32dec_pkg::PAD_CHAR) begin
      pad_cnt = pad_cnt + 4'd1;
    end else begin
      if (pad_cnt != 0) begin
        flag_error(b32dec_pkg::ST_PADDING, lst);
        return;
      end
      known = 1'b1;
      val = '0;
      if (ch >= "A" && ch <= "Z") begin
        val = 5'(ch - "A");
      end else if (ch >= "a" && ch <= "z") begin
        val = 5'(ch - "a");
      end else if (ch >= "2" && ch <= "7") begin
        val = 5'(ch - "2" + 8'd26);
      end else begin
        known = 1'b0;
      end
      if (!known) begin
        flag_error(b32dec_pkg::ST_SYMBOL, lst);
        return;
      end
      grp_bits = {grp_bits[34:0], val};
    end
    if (sym_cnt == b32dec_pkg::GROUP_LAST) begin
      case (pad_cnt)
        4'd0:    begin nbytes = 5; shift = 0; end
        4'd1:    begin nbytes = 4; shift = 3; end
        4'd3:    begin nbytes = 3; shift = 1; end
        4'd4:    begin nbytes = 2; shift = 4; end
        4'd6:    begin nbytes = 1; shift = 2; end
        default: begin nbytes = 0; shift = 0; end
      endcase
      if (nbytes == 0 || (pad_cnt != 0 && !lst)) begin
        flag_error(b32dec_pkg::ST_PADDING, lst);
        return;
      end
      aligned = grp_bits >> shift;
      for (int k = 0; k < nbytes; k++) begin
        owed_q.push_back('{8'(aligned >> (8 * (nbytes - 1 - k))), k == nbytes - 1,
                           k == nbytes - 1 && lst, b32dec_pkg::ST_OK});
      end
      clear_group();
      return;
    end
    if (lst) begin
      flag_error(b32dec_pkg::ST_LENGTH, 1'b1);
      return;
    end
    sym_cnt = sym_cnt + 3'd1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_group();
      owed_q.delete();
    end else begin
      if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          report($sformatf("unexpected word data %02h user %03b last %b",
                           m_tdata, m_tuser, m_tlast));
        end else begin
          want = owed_q.pop_front();
          if (m_tdata !== want.data)
            report($sformatf("data_byte %02h, want %02h", m_tdata, want.data));
          if (m_tuser[0] !== want.run_end)
            report($sformatf("run_end %b, want %b", m_tuser[0], want.run_end));
          if (m_tlast !== want.text_done)
            report($sformatf("text_done %b, want %b", m_tlast, want.text_done));
          if (m_tuser[2:1] !== want.status)
            report($sformatf("status %0d, want %0d", m_tuser[2:1], want.status));
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  int          results_owed;
  int          mismatches;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int          chars_sent = 0;
  logic        src_gaps = 1'b1;
  logic        sink_stalls = 1'b1;
  logic [7:0]  text_q[$];

  base32_strict_decoder_top u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  b32_stream_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .results_owed(results_owed),
    .mismatches  (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold ready low in random bursts while sink_stalls is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 31);
    if (r < 26) return ($urandom_range(0, 1) ? "A" : "a") + 8'(r);
    return "2" + 8'(r - 26);
  endfunction

  function automatic int pick_legal_pads();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 3;
      3:       return 4;
      default: return 6;
    endcase
  endfunction

  function automatic void add_group(input int pads);
    repeat (8 - pads) text_q.push_back(pick_symbol());
    repeat (pads) text_q.push_back("=");
  endfunction

  function automatic void add_string(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic lst);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      s_tlast <= 1'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // drop valid and hold until every owed result is out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int kind;
    int cut;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_string("7777777aab======");
    send_text();
    add_string("A");
    text_q.push_back(8'hFF);
    add_string("B");
    send_text();
    add_string("=");
    text_q.push_back(8'h00);
    send_text();
    add_string("a");
    send_text();
    wait_drained();

    while (chars_sent < 440) begin
      src_gaps = $urandom_range(0, 3) != 0;
      sink_stalls <= $urandom_range(0, 3) != 0;
      repeat ($urandom_range(0, 2)) add_group(0);
      kind = $urandom_range(0, 11);
      case (kind)
        7: begin
          add_group(pick_legal_pads());
          text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        8: begin
          case ($urandom_range(0, 3))
            0:       add_group(2);
            1:       add_group(5);
            2:       add_group(7);
            default: add_group(8);
          endcase
          if ($urandom_range(0, 1)) add_group(0);
        end
        9: begin
          add_group(pick_legal_pads());
          if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 7)) text_q.push_back(pick_symbol());
          end else begin
            cut = $urandom_range(1, 7);
            repeat (cut) void'(text_q.pop_back());
          end
        end
        10: begin
          add_group($urandom_range(0, 1) ? 1 : 6);
          add_group(0);
        end
        11: begin
          repeat ($urandom_range(1, 12)) begin
            text_q.push_back($urandom_range(0, 2) == 0 ? "=" : 8'($urandom_range(0, 255)));
          end
        end
        default: add_group(pick_legal_pads());
      endcase
      send_text();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    src_gaps = 1'b0;
    sink_stalls <= 1'b0;
    repeat (4) begin
      repeat ($urandom_range(0, 2)) add_group(0);
      add_group(pick_legal_pads());
      send_text();
    end
    wait_drained();
    repeat (30) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
